>>> rtl/rms_pkg.sv
// Package for the robot mode supervisor: field widths, register indexes,
// reset values, mode, event and command codes, and the lamp pattern table.
// No dependencies.
`default_nettype none

package rms_pkg;

   localparam int MvWidth       = 16;
   localparam int CmdWidth      = 8;
   localparam int OpWidth       = 2;
   localparam int ModeWidth     = 2;
   localparam int LedWidth      = 3;
   localparam int PctWidth      = 7;
   localparam int StopWidth     = 2;
   localparam int CountWidth    = 32;
   localparam int CsrIndexWidth = 2;
   localparam int ProdWidth     = 23;

   localparam int ReqDataWidth  = 32;
   localparam int RspDataWidth  = 88;
   localparam int RspFieldWidth = 81;

   localparam logic [CsrIndexWidth-1:0] CSR_CRITICAL = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LOW      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_FULL     = 2'd2;

   localparam logic [MvWidth-1:0] CRITICAL_RESET = 16'd20000;
   localparam logic [MvWidth-1:0] LOW_RESET      = 16'd22000;
   localparam logic [MvWidth-1:0] FULL_RESET     = 16'd25200;

   localparam logic [PctWidth-1:0] PCT_FULL = 7'd100;

   localparam logic [ModeWidth-1:0] MODE_IDLE   = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_MANUAL = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_AUTO   = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_EMERG  = 2'd3;

   localparam logic [OpWidth-1:0] OP_TICK     = 2'd0;
   localparam logic [OpWidth-1:0] OP_CMD      = 2'd1;
   localparam logic [OpWidth-1:0] OP_WAYPOINT = 2'd2;
   localparam logic [OpWidth-1:0] OP_OBSTACLE = 2'd3;

   localparam logic [CmdWidth-1:0] CMD_STOP   = 8'd0;
   localparam logic [CmdWidth-1:0] CMD_MANUAL = 8'd1;
   localparam logic [CmdWidth-1:0] CMD_AUTO   = 8'd2;

   localparam logic [LedWidth-1:0] LED_GREEN       = 3'd1;
   localparam logic [LedWidth-1:0] LED_RED         = 3'd2;
   localparam logic [LedWidth-1:0] LED_BLUE        = 3'd4;
   localparam logic [LedWidth-1:0] LED_GREEN_BLUE  = 3'd5;

   typedef logic [ModeWidth-1:0] mode_type;

   function automatic logic [LedWidth-1:0] lamp_for(input mode_type m);
      logic [LedWidth-1:0] led;
      case (m)
         MODE_IDLE:   led = LED_GREEN;
         MODE_MANUAL: led = LED_BLUE;
         MODE_AUTO:   led = LED_GREEN_BLUE;
         default:     led = LED_RED;
      endcase
      return led;
   endfunction

endpackage

`default_nettype wire

>>> rtl/robot_mode_supervisor.sv
// Robot mode supervisor: the mode machine, event counters, battery sampling
// and the bit-serial percentage divider. Uses rms_pkg.
//
// One word in, one word out. A tick passes through latch, prepare, seven
// restoring division steps and commit; a mode command, waypoint or obstacle
// word goes straight from prepare to commit. The seven-step divider yields
// one quotient bit per cycle through a shifting divisor register. A new word
// is taken as soon as the previous one has been committed to the output
// register, even while that result still waits to be taken.
// Configuration writes are taken at once and have no read-back.
`default_nettype none

module robot_mode_supervisor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: battery_mv[15:0], estop_in[16], command[24:17], zero pad
   input  wire logic [rms_pkg::ReqDataWidth-1:0]  req_tdata,
   // tuser: operation[1:0]
   input  wire logic [rms_pkg::OpWidth-1:0]       req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: mode[1:0], led_pattern[4:2], charge_level[11:5], low_battery[12],
   // stop_broadcasts[14:13], heartbeat_sent[15], obstacle_forward[16],
   // uptime_seconds[48:17], waypoint_count[80:49], zero pad
   output logic [rms_pkg::RspDataWidth-1:0]       rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_wen,
   input  wire logic [rms_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [rms_pkg::MvWidth-1:0]       csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [2:0] DIV_LAST = 3'd6;

   logic [1:0]                           state_ff, state_in;
   logic [2:0]                           cnt_ff, cnt_in;

   logic [rms_pkg::MvWidth-1:0]          crit_ff, low_ff, full_ff;

   logic [rms_pkg::OpWidth-1:0]          op_ff;
   logic [rms_pkg::MvWidth-1:0]          mv_ff;
   logic                                 estop_ff;
   logic [rms_pkg::CmdWidth-1:0]         cmd_ff;

   logic                                 ge_full_ff, le_crit_ff, lt_crit_ff, lt_low_ff;
   logic [rms_pkg::ProdWidth-1:0]        rem_ff, rem_in;
   logic [rms_pkg::ProdWidth-1:0]        dsh_ff, dsh_in;
   logic [rms_pkg::PctWidth-1:0]         quo_ff, quo_in;

   rms_pkg::mode_type                    mode_ff, mode_in;
   logic [rms_pkg::CountWidth-1:0]       uptime_ff, uptime_in;
   logic [rms_pkg::CountWidth-1:0]       wp_ff, wp_in;
   logic [rms_pkg::PctWidth-1:0]         pct_ff, pct_in;
   logic                                 lowflag_ff, lowflag_in;

   logic                                 rsp_valid_ff;
   logic [rms_pkg::RspFieldWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic                                 accept;
   logic                                 commit;
   logic [rms_pkg::MvWidth-1:0]          diff;
   logic [rms_pkg::ProdWidth-1:0]        prod;
   logic [rms_pkg::ProdWidth:0]          trial;
   logic [rms_pkg::StopWidth-1:0]        stops;
   logic                                 heart;
   logic                                 fwd;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rms_pkg::RspDataWidth - rms_pkg::RspFieldWidth){1'b0}}, rsp_data_ff};

   // (mv - critical) * 100 as shift-and-add
   assign diff  = mv_ff - crit_ff;
   assign prod  = {1'b0, diff, 6'b0} + {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
   assign trial = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in = prod;
            dsh_in = {1'b0, full_ff - crit_ff, 6'b0};
            quo_in = '0;
            cnt_in = '0;
            state_in = (op_ff == rms_pkg::OP_TICK) ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (!trial[rms_pkg::ProdWidth]) begin
               rem_in = trial[rms_pkg::ProdWidth-1:0];
            end
            quo_in = {quo_ff[rms_pkg::PctWidth-2:0], ~trial[rms_pkg::ProdWidth]};
            dsh_in = {1'b0, dsh_ff[rms_pkg::ProdWidth-1:1]};
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      uptime_in  = uptime_ff;
      wp_in      = wp_ff;
      pct_in     = pct_ff;
      lowflag_in = lowflag_ff;
      stops      = '0;
      heart      = 1'b0;
      fwd        = 1'b0;
      case (op_ff)
         rms_pkg::OP_TICK: begin
            uptime_in  = uptime_ff + 32'd1;
            lowflag_in = lt_low_ff;
            if (ge_full_ff) begin
               pct_in = rms_pkg::PCT_FULL;
            end else if (le_crit_ff) begin
               pct_in = '0;
            end else begin
               pct_in = quo_ff;
            end
            case (mode_ff)
               rms_pkg::MODE_IDLE: begin
                  heart = 1'b1;
                  if (estop_ff) mode_in = rms_pkg::MODE_EMERG;
               end
               rms_pkg::MODE_MANUAL: begin
                  if (estop_ff || lt_crit_ff) mode_in = rms_pkg::MODE_EMERG;
               end
               rms_pkg::MODE_AUTO: begin
                  if (estop_ff) begin
                     mode_in = rms_pkg::MODE_EMERG;
                  end else if (lt_crit_ff) begin
                     stops   = 2'd1;
                     mode_in = rms_pkg::MODE_EMERG;
                  end
               end
               default: begin
                  if (!estop_ff && !lt_low_ff) mode_in = rms_pkg::MODE_IDLE;
               end
            endcase
         end
         rms_pkg::OP_CMD: begin
            case (mode_ff)
               rms_pkg::MODE_IDLE: begin
                  if (cmd_ff == rms_pkg::CMD_MANUAL) mode_in = rms_pkg::MODE_MANUAL;
                  else if (cmd_ff == rms_pkg::CMD_AUTO) mode_in = rms_pkg::MODE_AUTO;
               end
               rms_pkg::MODE_MANUAL: begin
                  if (cmd_ff == rms_pkg::CMD_STOP) mode_in = rms_pkg::MODE_IDLE;
                  else if (cmd_ff == rms_pkg::CMD_AUTO) mode_in = rms_pkg::MODE_AUTO;
               end
               rms_pkg::MODE_AUTO: begin
                  if (cmd_ff == rms_pkg::CMD_STOP) begin
                     stops   = 2'd1;
                     mode_in = rms_pkg::MODE_IDLE;
                  end else if (cmd_ff == rms_pkg::CMD_MANUAL) begin
                     mode_in = rms_pkg::MODE_MANUAL;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
         rms_pkg::OP_WAYPOINT: begin
            if (mode_ff == rms_pkg::MODE_IDLE || mode_ff == rms_pkg::MODE_AUTO) begin
               wp_in = wp_ff + 32'd1;
            end
         end
         default: begin
            fwd = (mode_ff == rms_pkg::MODE_AUTO);
         end
      endcase
      if (mode_in == rms_pkg::MODE_EMERG && mode_ff != rms_pkg::MODE_EMERG) begin
         stops = stops + 2'd1;
      end
      rsp_data_in = {wp_in, uptime_in, fwd, heart, stops, lowflag_in, pct_in,
                     rms_pkg::lamp_for(mode_in), mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         crit_ff      <= rms_pkg::CRITICAL_RESET;
         low_ff       <= rms_pkg::LOW_RESET;
         full_ff      <= rms_pkg::FULL_RESET;
         mode_ff      <= rms_pkg::MODE_IDLE;
         uptime_ff    <= '0;
         wp_ff        <= '0;
         pct_ff       <= '0;
         lowflag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wen) begin
            case (csr_index)
               rms_pkg::CSR_CRITICAL: crit_ff <= csr_wdata;
               rms_pkg::CSR_LOW:      low_ff  <= csr_wdata;
               rms_pkg::CSR_FULL:     full_ff <= csr_wdata;
               default:               crit_ff <= crit_ff;
            endcase
         end
         if (commit) begin
            mode_ff      <= mode_in;
            uptime_ff    <= uptime_in;
            wp_ff        <= wp_in;
            pct_ff       <= pct_in;
            lowflag_ff   <= lowflag_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (accept) begin
         op_ff    <= req_tuser;
         mv_ff    <= req_tdata[rms_pkg::MvWidth-1:0];
         estop_ff <= req_tdata[rms_pkg::MvWidth];
         cmd_ff   <= req_tdata[rms_pkg::MvWidth+rms_pkg::CmdWidth:rms_pkg::MvWidth+1];
      end
      if (state_ff == ST_PREP) begin
         ge_full_ff <= (mv_ff >= full_ff);
         le_crit_ff <= (mv_ff <= crit_ff);
         lt_crit_ff <= (mv_ff < crit_ff);
         lt_low_ff  <= (mv_ff < low_ff);
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_lamp_follows_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[4:2] == rms_pkg::lamp_for(rsp_data_ff[1:0]))
      else $error("lamp pattern does not match reported mode");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      pct_ff <= rms_pkg::PCT_FULL)
      else $error("battery percentage above full scale");

   a_stops_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[14:13] != 2'd3)
      else $error("more than two stop broadcasts in one word");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PREP)
      else $error("accepted word did not start processing");

   a_divider_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff <= DIV_LAST)
      else $error("divider step count overran");

endmodule

`default_nettype wire
